@@ sv/ws2811_pixel_serializer_assert.svh @@
// assertion macros for the ws2811 pixel serializer
// depends on nothing; included by the top level
`ifndef WS2811_PIXEL_SERIALIZER_ASSERT_SVH
`define WS2811_PIXEL_SERIALIZER_ASSERT_SVH

`ifndef SYNTH
`define WS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");
`define WS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define WS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define WS_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ sv/ws2811ps_pkg.sv @@
// shared types and constants of the ws2811 pixel serializer
// depends on nothing
package ws2811ps_pkg;

  localparam int unsigned TickW = 10;
  localparam int unsigned ColorW = 8;
  localparam int unsigned ShiftW = 3 * ColorW;
  localparam int unsigned BitsW = 5;
  localparam int unsigned CfgIdxW = 2;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW = $clog2(QueueDepth);
  localparam int unsigned QueueCntW = QueuePtrW + 1;
  localparam logic [QueueCntW-1:0] QueueFull = QueueCntW'(QueueDepth);

  localparam logic [BitsW-1:0] BitsPerPixel = 5'd24;

  localparam logic [TickW-1:0] OneHighRst = 10'd96;
  localparam logic [TickW-1:0] OneLowRst = 10'd104;
  localparam logic [TickW-1:0] ZeroHighRst = 10'd40;
  localparam logic [TickW-1:0] ZeroLowRst = 10'd160;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ONE_HIGH = 2'd0,
    CFG_ONE_LOW = 2'd1,
    CFG_ZERO_HIGH = 2'd2,
    CFG_ZERO_LOW = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [TickW-1:0] one_high;
    logic [TickW-1:0] one_low;
    logic [TickW-1:0] zero_high;
    logic [TickW-1:0] zero_low;
  } cfg_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic accepted;
    logic pixel_done;
  } result_t;

endpackage

@@ sv/ws2811ps_core.sv @@
// bit timing and shift state of the ws2811 pixel serializer
// depends on ws2811ps_pkg
module ws2811ps_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                valid_i,
  input  ws2811ps_pkg::op_e                   op_i,
  input  logic [ws2811ps_pkg::ColorW-1:0]     red_i,
  input  logic [ws2811ps_pkg::ColorW-1:0]     green_i,
  input  logic [ws2811ps_pkg::ColorW-1:0]     blue_i,
  input  ws2811ps_pkg::cfg_t                  cfg_i,
  output ws2811ps_pkg::result_t               res_o
);

  logic [ws2811ps_pkg::ShiftW-1:0] shift_q, shift_d;
  logic [ws2811ps_pkg::BitsW-1:0]  bits_q, bits_d;
  logic [ws2811ps_pkg::TickW-1:0]  count_q, count_d;
  logic                            high_q, high_d;
  logic                            active_q, active_d;

  logic [ws2811ps_pkg::TickW-1:0]  count_inc;
  logic [ws2811ps_pkg::TickW-1:0]  phase_len;
  logic [ws2811ps_pkg::BitsW-1:0]  bits_dec;
  logic                            cur_bit;

  assign cur_bit   = shift_q[ws2811ps_pkg::ShiftW-1];
  assign count_inc = count_q + 1'b1;
  assign bits_dec  = bits_q - 1'b1;

  always_comb begin
    if (high_q) begin
      phase_len = cur_bit ? cfg_i.one_high : cfg_i.zero_high;
    end else begin
      phase_len = cur_bit ? cfg_i.one_low : cfg_i.zero_low;
    end
  end

  always_comb begin
    shift_d  = shift_q;
    bits_d   = bits_q;
    count_d  = count_q;
    high_d   = high_q;
    active_d = active_q;
    res_o.line_level = active_q & high_q;
    res_o.accepted   = 1'b0;
    res_o.pixel_done = 1'b0;
    if (valid_i) begin
      case (op_i)
        ws2811ps_pkg::OP_LOAD: begin
          if (!active_q) begin
            shift_d  = {blue_i, red_i, green_i};
            bits_d   = ws2811ps_pkg::BitsPerPixel;
            count_d  = '0;
            high_d   = 1'b1;
            active_d = 1'b1;
            res_o.accepted = 1'b1;
          end
        end
        ws2811ps_pkg::OP_TICK: begin
          if (active_q) begin
            count_d = count_inc;
            if (count_inc >= phase_len) begin
              count_d = '0;
              if (high_q) begin
                high_d = 1'b0;
              end else begin
                shift_d = {shift_q[ws2811ps_pkg::ShiftW-2:0], 1'b0};
                bits_d  = bits_dec;
                if (bits_dec == '0) begin
                  active_d = 1'b0;
                  res_o.pixel_done = 1'b1;
                end else begin
                  high_d = 1'b1;
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
    res_o.busy_res = active_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q  <= '0;
      bits_q   <= '0;
      count_q  <= '0;
      high_q   <= 1'b0;
      active_q <= 1'b0;
    end else begin
      shift_q  <= shift_d;
      bits_q   <= bits_d;
      count_q  <= count_d;
      high_q   <= high_d;
      active_q <= active_d;
    end
  end

endmodule

@@ sv/ws2811_pixel_serializer.sv @@
// top level of the ws2811 pixel serializer: input register, config registers, result queue
// depends on ws2811ps_pkg, ws2811ps_core and ws2811_pixel_serializer_assert.svh
//
// usage
// - input channel (in_valid_i / in_stall_o) carries one beat per item: op_i selects a
//   pixel load (red_i, green_i, blue_i) or one tick of waveform time
// - output channel (out_valid_o / out_stall_i) returns exactly one result beat per item:
//   line level, busy flag, load taken flag and end-of-pixel flag
// - config channel (cfg_valid_i / cfg_ready_o) writes the four phase lengths, counted in
//   tick items, indexed by cfg_index_i; cfg_ready_o is always high
// - each result passes the input register and then the result queue on its way out
// - throughput is one item per cycle unless stalled; the input register feeds the timing
//   logic, and the result lands in a four-entry queue whose fill level sets in_stall_o
// - in_stall_o rises only when the queue plus the item in the input register reach
//   four, so a stalled receiver backs up into the sender without losing beats
// - reset clears the queue and the serializer state, idles the line low and loads the
//   default phase lengths; the block takes items in the first cycle after reset
`include "ws2811_pixel_serializer_assert.svh"

module ws2811_pixel_serializer (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 op_i,
  input  logic [ws2811ps_pkg::ColorW-1:0]      red_i,
  input  logic [ws2811ps_pkg::ColorW-1:0]      green_i,
  input  logic [ws2811ps_pkg::ColorW-1:0]      blue_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 line_level_o,
  output logic                                 busy_res_o,
  output logic                                 accepted_o,
  output logic                                 pixel_done_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [ws2811ps_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [ws2811ps_pkg::TickW-1:0]       cfg_data_i
);

  logic                              in_valid_q;
  ws2811ps_pkg::op_e                 op_q;
  logic [ws2811ps_pkg::ColorW-1:0]   red_q, green_q, blue_q;
  logic                              in_accept;

  ws2811ps_pkg::cfg_t                cfg_q, cfg_d;

  ws2811ps_pkg::result_t             res;
  ws2811ps_pkg::result_t             queue_q [ws2811ps_pkg::QueueDepth];
  ws2811ps_pkg::result_t             head;
  logic [ws2811ps_pkg::QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [ws2811ps_pkg::QueueCntW-1:0] count_q, count_d;
  logic [ws2811ps_pkg::QueueCntW-1:0] occupancy;
  logic                              push, pop;

  // input register
  assign occupancy  = count_q + {{ws2811ps_pkg::QueuePtrW{1'b0}}, in_valid_q};
  assign in_stall_o = occupancy >= ws2811ps_pkg::QueueFull;
  assign in_accept  = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q    <= ws2811ps_pkg::op_e'(op_i);
      red_q   <= red_i;
      green_q <= green_i;
      blue_q  <= blue_i;
    end
  end

  // config registers
  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (ws2811ps_pkg::cfg_idx_e'(cfg_index_i))
        ws2811ps_pkg::CFG_ONE_HIGH:  cfg_d.one_high  = cfg_data_i;
        ws2811ps_pkg::CFG_ONE_LOW:   cfg_d.one_low   = cfg_data_i;
        ws2811ps_pkg::CFG_ZERO_HIGH: cfg_d.zero_high = cfg_data_i;
        ws2811ps_pkg::CFG_ZERO_LOW:  cfg_d.zero_low  = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.one_high  <= ws2811ps_pkg::OneHighRst;
      cfg_q.one_low   <= ws2811ps_pkg::OneLowRst;
      cfg_q.zero_high <= ws2811ps_pkg::ZeroHighRst;
      cfg_q.zero_low  <= ws2811ps_pkg::ZeroLowRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  ws2811ps_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_q),
    .op_i    (op_q),
    .red_i   (red_q),
    .green_i (green_q),
    .blue_i  (blue_q),
    .cfg_i   (cfg_q),
    .res_o   (res)
  );

  // result queue
  assign push        = in_valid_q;
  assign out_valid_o = count_q != '0;
  assign pop         = out_valid_o & ~out_stall_i;
  assign head        = queue_q[rd_ptr_q];

  assign line_level_o = head.line_level;
  assign busy_res_o   = head.busy_res;
  assign accepted_o   = head.accepted;
  assign pixel_done_o = head.pixel_done;

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= res;
    end
  end

  `WS_ASSERT_IMP(a_queue_bound, clk_i, rst_ni, 1'b1, occupancy <= ws2811ps_pkg::QueueFull)
  `WS_ASSERT_IMP(a_done_idle, clk_i, rst_ni, push && res.pixel_done, !res.busy_res)
  `WS_ASSERT_IMP(a_load_busy, clk_i, rst_ni, push && res.accepted, res.busy_res)
  `WS_ASSERT_NXT(a_push_seen, clk_i, rst_ni, push, out_valid_o)

endmodule

@@ test/tb_ws2811_pixel_serializer.sv @@
// self-checking testbench for ws2811_pixel_serializer: directed table, then random pixel traffic
// keeps its own copy of the line timing state and compares every result beat field by field
// depends on ws2811ps_pkg and the serializer rtl
`timescale 1ns / 1ps

module tb_ws2811_pixel_serializer;

  localparam int unsigned QuietLimit = 2000;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned PhaseItems = 200;
  localparam int unsigned NumPhases = 5;

  typedef enum logic {
    ROW_ITEM,
    ROW_REG
  } row_kind_e;

  typedef struct {
    row_kind_e                           kind;
    ws2811ps_pkg::op_e                   op;
    logic [7:0]                          red;
    logic [7:0]                          green;
    logic [7:0]                          blue;
    ws2811ps_pkg::cfg_idx_e              reg_idx;
    logic [ws2811ps_pkg::TickW-1:0]      reg_val;
    bit                                  typed;
    ws2811ps_pkg::result_t               want;
  } row_t;

  logic                               clk_i;
  logic                               rst_ni;
  logic                               in_valid_i;
  logic                               in_stall_o;
  logic                               op_i;
  logic [ws2811ps_pkg::ColorW-1:0]    red_i;
  logic [ws2811ps_pkg::ColorW-1:0]    green_i;
  logic [ws2811ps_pkg::ColorW-1:0]    blue_i;
  logic                               out_valid_o;
  logic                               out_stall_i;
  logic                               line_level_o;
  logic                               busy_res_o;
  logic                               accepted_o;
  logic                               pixel_done_o;
  logic                               cfg_valid_i;
  logic                               cfg_ready_o;
  logic [ws2811ps_pkg::CfgIdxW-1:0]   cfg_index_i;
  logic [ws2811ps_pkg::TickW-1:0]     cfg_data_i;

  ws2811_pixel_serializer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .op_i        (op_i),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .line_level_o(line_level_o),
    .busy_res_o  (busy_res_o),
    .accepted_o  (accepted_o),
    .pixel_done_o(pixel_done_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  // line timing state kept alongside the dut
  ws2811ps_pkg::cfg_t                 phase_len;
  logic [ws2811ps_pkg::ShiftW-1:0]    line_bits;
  logic [ws2811ps_pkg::BitsW-1:0]     bits_left;
  logic [ws2811ps_pkg::TickW-1:0]     phase_ticks;
  logic                               high_phase;
  logic                               sending;

  ws2811ps_pkg::result_t pending_results[$];
  row_t                  plan[$];

  int err_count;
  int item_count;
  int load_count;
  int drop_count;
  int pixel_count;
  int reg_writes;
  int burst_left;
  int quiet_cycles;
  int hold_left;
  int seg_left;
  int stall_mode;
  bit hold_req;
  bit no_gap;

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  task automatic advance_line(input ws2811ps_pkg::op_e op, input logic [7:0] red,
                              input logic [7:0] green, input logic [7:0] blue,
                              output ws2811ps_pkg::result_t res);
    logic [ws2811ps_pkg::TickW-1:0] len;
    res = '0;
    res.line_level = sending && high_phase;
    if (op == ws2811ps_pkg::OP_LOAD) begin
      if (!sending) begin
        line_bits = {blue, red, green};
        bits_left = ws2811ps_pkg::BitsPerPixel;
        phase_ticks = '0;
        high_phase = 1'b1;
        sending = 1'b1;
        res.accepted = 1'b1;
        load_count++;
      end else begin
        drop_count++;
      end
    end else if (sending) begin
      phase_ticks = phase_ticks + 1'b1;
      if (high_phase) begin
        len = line_bits[ws2811ps_pkg::ShiftW-1] ? phase_len.one_high : phase_len.zero_high;
      end else begin
        len = line_bits[ws2811ps_pkg::ShiftW-1] ? phase_len.one_low : phase_len.zero_low;
      end
      if (phase_ticks >= len) begin
        phase_ticks = '0;
        if (high_phase) begin
          high_phase = 1'b0;
        end else begin
          line_bits = line_bits << 1;
          bits_left = bits_left - 1'b1;
          if (bits_left == '0) begin
            sending = 1'b0;
            res.pixel_done = 1'b1;
            pixel_count++;
          end else begin
            high_phase = 1'b1;
          end
        end
      end
    end
    res.busy_res = sending;
  endtask

  function automatic row_t item_row(ws2811ps_pkg::op_e op, logic [7:0] red, logic [7:0] green,
                                    logic [7:0] blue, bit typed, ws2811ps_pkg::result_t want);
    row_t r;
    r.kind = ROW_ITEM;
    r.op = op;
    r.red = red;
    r.green = green;
    r.blue = blue;
    r.reg_idx = ws2811ps_pkg::CFG_ONE_HIGH;
    r.reg_val = '0;
    r.typed = typed;
    r.want = want;
    return r;
  endfunction

  function automatic row_t reg_row(ws2811ps_pkg::cfg_idx_e idx,
                                   logic [ws2811ps_pkg::TickW-1:0] val);
    row_t r;
    r = item_row(ws2811ps_pkg::OP_TICK, 8'h00, 8'h00, 8'h00, 1'b0, '0);
    r.kind = ROW_REG;
    r.reg_idx = idx;
    r.reg_val = val;
    return r;
  endfunction

  function automatic logic [ws2811ps_pkg::TickW-1:0] rand_len(int lo, int hi);
    logic [31:0] v;
    v = $urandom_range(lo, hi);
    return v[ws2811ps_pkg::TickW-1:0];
  endfunction

  // called at a falling edge; sender bursts with random gaps
  task automatic pace_sender();
    if (no_gap) return;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 30);
    end
    burst_left--;
  endtask

  task automatic send_item(ws2811ps_pkg::op_e op, logic [7:0] red, logic [7:0] green,
                           logic [7:0] blue, bit typed, ws2811ps_pkg::result_t want);
    ws2811ps_pkg::result_t pred;
    pace_sender();
    in_valid_i <= 1'b1;
    op_i <= op;
    red_i <= red;
    green_i <= green;
    blue_i <= blue;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    advance_line(op, red, green, blue, pred);
    pending_results.push_back(typed ? want : pred);
    item_count++;
    @(negedge clk_i);
  endtask

  // pause the sender until every result is back, then let the pipeline go quiet
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(ws2811ps_pkg::cfg_idx_e idx, logic [ws2811ps_pkg::TickW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      ws2811ps_pkg::CFG_ONE_HIGH:  phase_len.one_high = val;
      ws2811ps_pkg::CFG_ONE_LOW:   phase_len.one_low = val;
      ws2811ps_pkg::CFG_ZERO_HIGH: phase_len.zero_high = val;
      ws2811ps_pkg::CFG_ZERO_LOW:  phase_len.zero_low = val;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // result checker
  always @(posedge clk_i) begin : check_results
    ws2811ps_pkg::result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result beat with nothing expected");
        err_count++;
      end else begin
        want = pending_results.pop_front();
        if (line_level_o !== want.line_level) begin
          $error("line_level: expected %0b, got %0b", want.line_level, line_level_o);
          err_count++;
        end
        if (busy_res_o !== want.busy_res) begin
          $error("busy_res: expected %0b, got %0b", want.busy_res, busy_res_o);
          err_count++;
        end
        if (accepted_o !== want.accepted) begin
          $error("accepted: expected %0b, got %0b", want.accepted, accepted_o);
          err_count++;
        end
        if (pixel_done_o !== want.pixel_done) begin
          $error("pixel_done: expected %0b, got %0b", want.pixel_done, pixel_done_o);
          err_count++;
        end
      end
    end
  end

  // watchdog on cycles with no beat on any channel
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles = 0;
    end else if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
                 (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QuietLimit) begin
        $display("timeout with %0d results outstanding", pending_results.size());
        $display("FAILURE");
        $finish;
      end
    end
  end

  // receiver stall pattern, with a long hold-off on request
  initial begin : receiver
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HoldCycles - 1;
        out_stall_i <= 1'b1;
      end else begin
        if (seg_left == 0) begin
          stall_mode = $urandom_range(0, 3);
          seg_left = $urandom_range(20, 120);
        end
        seg_left--;
        case (stall_mode)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          2: out_stall_i <= ~out_stall_i;
          default: out_stall_i <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  initial begin : stimulus
    ws2811ps_pkg::op_e op;
    row_t              r;
    logic [7:0]        red;
    logic [7:0]        green;
    logic [7:0]        blue;
    int                lo;
    int                hi;

    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    op_i = ws2811ps_pkg::OP_TICK;
    red_i = '0;
    green_i = '0;
    blue_i = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = ws2811ps_pkg::CFG_ONE_HIGH;
    cfg_data_i = '0;
    phase_len = '{one_high: ws2811ps_pkg::OneHighRst, one_low: ws2811ps_pkg::OneLowRst,
                  zero_high: ws2811ps_pkg::ZeroHighRst, zero_low: ws2811ps_pkg::ZeroLowRst};
    line_bits = '0;
    bits_left = '0;
    phase_ticks = '0;
    high_phase = 1'b0;
    sending = 1'b0;
    burst_left = 0;
    seg_left = 0;
    stall_mode = 0;
    hold_left = 0;
    hold_req = 1'b0;
    no_gap = 1'b0;

    // tick while idle, load, load while busy, then mid-phase and zero-length writes
    plan.push_back(item_row(ws2811ps_pkg::OP_TICK, 8'h00, 8'h00, 8'h00, 1'b1,
                            ws2811ps_pkg::result_t'(4'b0000)));
    plan.push_back(item_row(ws2811ps_pkg::OP_LOAD, 8'h00, 8'h00, 8'h00, 1'b1,
                            ws2811ps_pkg::result_t'(4'b0110)));
    plan.push_back(item_row(ws2811ps_pkg::OP_LOAD, 8'hff, 8'hff, 8'hff, 1'b1,
                            ws2811ps_pkg::result_t'(4'b1100)));
    plan.push_back(item_row(ws2811ps_pkg::OP_TICK, 8'hff, 8'hff, 8'hff, 1'b1,
                            ws2811ps_pkg::result_t'(4'b1100)));
    plan.push_back(reg_row(ws2811ps_pkg::CFG_ZERO_HIGH, 10'd1));
    plan.push_back(item_row(ws2811ps_pkg::OP_TICK, 8'h00, 8'h00, 8'h00, 1'b0, '0));
    plan.push_back(reg_row(ws2811ps_pkg::CFG_ZERO_LOW, 10'd0));
    repeat (3) plan.push_back(item_row(ws2811ps_pkg::OP_TICK, 8'h00, 8'h00, 8'h00, 1'b0, '0));
    plan.push_back(reg_row(ws2811ps_pkg::CFG_ZERO_HIGH, 10'd1023));
    repeat (2) plan.push_back(item_row(ws2811ps_pkg::OP_TICK, 8'hff, 8'hff, 8'hff, 1'b0, '0));
    plan.push_back(reg_row(ws2811ps_pkg::CFG_ZERO_HIGH, 10'd2));
    plan.push_back(item_row(ws2811ps_pkg::OP_TICK, 8'h00, 8'h00, 8'h00, 1'b0, '0));
    plan.push_back(reg_row(ws2811ps_pkg::CFG_ONE_HIGH, 10'd1023));
    plan.push_back(reg_row(ws2811ps_pkg::CFG_ONE_LOW, 10'd1023));
    plan.push_back(item_row(ws2811ps_pkg::OP_LOAD, 8'h5a, 8'ha5, 8'h3c, 1'b0, '0));
    repeat (2) plan.push_back(item_row(ws2811ps_pkg::OP_TICK, 8'h00, 8'h00, 8'h00, 1'b0, '0));

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan[i]) begin
      r = plan[i];
      if (r.kind == ROW_REG) begin
        settle();
        write_reg(r.reg_idx, r.reg_val);
      end else begin
        send_item(r.op, r.red, r.green, r.blue, r.typed, r.want);
      end
    end

    // random phases, each with its own set of phase lengths
    for (int p = 0; p < NumPhases; p++) begin
      settle();
      lo = (p % 2 == 1) ? 0 : 1;
      hi = (p == 0) ? 1 : p + 1;
      write_reg(ws2811ps_pkg::CFG_ONE_HIGH, rand_len(lo, hi));
      write_reg(ws2811ps_pkg::CFG_ONE_LOW, rand_len(lo, hi));
      write_reg(ws2811ps_pkg::CFG_ZERO_HIGH, rand_len(lo, hi));
      write_reg(ws2811ps_pkg::CFG_ZERO_LOW, rand_len(lo, hi));
      for (int n = 0; n < PhaseItems; n++) begin
        if (p == 2 && n == 50) begin
          hold_req = 1'b1;
          no_gap = 1'b1;
        end
        if (p == 2 && n == 90) no_gap = 1'b0;
        if (!sending) begin
          op = ($urandom_range(0, 99) < 80) ? ws2811ps_pkg::OP_LOAD : ws2811ps_pkg::OP_TICK;
        end else begin
          op = ($urandom_range(0, 99) < 4) ? ws2811ps_pkg::OP_LOAD : ws2811ps_pkg::OP_TICK;
        end
        red = 8'($urandom_range(0, 255));
        green = 8'($urandom_range(0, 255));
        blue = 8'($urandom_range(0, 255));
        send_item(op, red, green, blue, 1'b0, '0);
      end
    end

    settle();
    repeat (8) @(negedge clk_i);

    $display("%0d items: %0d pixels loaded, %0d loads dropped, %0d pixels sent to the line",
             item_count, load_count, drop_count, pixel_count);
    $display("%0d phase length writes over %0d settings, %0d mismatches",
             reg_writes, NumPhases + 1, err_count);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ ws2811_pixel_serializer.f @@
+incdir+sv
sv/ws2811ps_pkg.sv
sv/ws2811ps_core.sv
sv/ws2811_pixel_serializer.sv
test/tb_ws2811_pixel_serializer.sv
